### design/atc_pkg.sv
// Shared constants and types for the array tile column allocator.
// No dependencies.
`default_nettype none

package atc_pkg;

    localparam int ATC_SIDE    = 8;
    localparam int ATC_CELLS   = ATC_SIDE * ATC_SIDE;
    localparam int ATC_NODES_W = 16;
    localparam int ATC_TOTAL_W = 24;
    localparam int ATC_XY_W    = 3;
    localparam int ATC_COL_W   = $clog2(ATC_SIDE);
    localparam int ATC_ROW_W   = 4;
    localparam int ATC_GRANT_W = $clog2(ATC_CELLS + 1);
    localparam int ATC_DIVD_W  = ATC_NODES_W + ATC_GRANT_W;
    localparam int ATC_SQ_W    = $clog2((ATC_SIDE + 1) * (ATC_SIDE + 1) + 1);

    typedef logic [ATC_SIDE-1:0][ATC_ROW_W-1:0] t_fill;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_ROOT = 5'b00100,
        S_FIT  = 5'b01000,
        S_TILE = 5'b10000
    } t_state;

endpackage

`default_nettype wire

### design/atc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on atc_pkg.
`default_nettype none

module atc_div (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire  [atc_pkg::ATC_DIVD_W-1:0]      i_dividend,
    input  wire  [atc_pkg::ATC_TOTAL_W-1:0]     i_divisor,
    output logic                                o_done,
    output logic [atc_pkg::ATC_DIVD_W-1:0]      o_quot
);
    import atc_pkg::*;

    localparam int CNT_W = $clog2(ATC_DIVD_W + 1);

    logic [ATC_TOTAL_W-1:0] r_rem, n_rem;
    logic [ATC_DIVD_W-1:0]  r_quot, n_quot;
    logic [ATC_TOTAL_W-1:0] r_div;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [ATC_TOTAL_W:0]   trial;
    logic [ATC_TOTAL_W:0]   diff;

    // shift the next dividend bit into the partial remainder and try a subtract
    always_comb begin
        trial  = {r_rem, r_quot[ATC_DIVD_W-1]};
        diff   = trial - {1'b0, r_div};
        n_rem  = r_rem;
        n_quot = r_quot;
        if (trial >= {1'b0, r_div}) begin
            n_rem  = diff[ATC_TOTAL_W-1:0];
            n_quot = {r_quot[ATC_DIVD_W-2:0], 1'b1};
        end else begin
            n_rem  = trial[ATC_TOTAL_W-1:0];
            n_quot = {r_quot[ATC_DIVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ATC_DIVD_W);
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

### design/array_tile_column_allocator.sv
// Flow: a serial divide (skipped when total_nodes is 0), a square-root search, a fit step, then tile steps.
// Throughput: one kernel at a time; busy stays high until the last tile step is done.
// Results come in the cycle after each tile step as a one-cycle strobe; no back-pressure.
// Synchronous active-low reset clears the column fill, cursor and sets total_nodes to 1.
// The divide is a serial unit, the square root a step-per-cycle search.
// Depends on atc_pkg and atc_div.
`default_nettype none

module array_tile_column_allocator (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [atc_pkg::ATC_TOTAL_W-1:0] i_cfg_total_nodes,
    input  wire                             start,
    output logic                            busy,
    input  wire  [atc_pkg::ATC_NODES_W-1:0] i_kernel_nodes,
    output logic                            o_valid,
    output logic [atc_pkg::ATC_XY_W-1:0]    o_tile_x,
    output logic [atc_pkg::ATC_XY_W-1:0]    o_tile_y,
    output logic                            o_last,
    output logic                            o_array_full
);
    import atc_pkg::*;

    localparam logic [ATC_ROW_W-1:0] SIDE_R = ATC_ROW_W'(ATC_SIDE);

    t_state                   r_state, n_state;
    logic [ATC_TOTAL_W-1:0]   r_total;
    logic [ATC_GRANT_W-1:0]   r_grant, r_left, n_left;
    logic [ATC_ROW_W-1:0]     r_root;
    logic [ATC_SQ_W-1:0]      r_sq;
    logic [ATC_ROW_W-1:0]     r_width, r_height;
    t_fill                    r_fill, n_fill;
    logic [ATC_COL_W-1:0]     r_col, n_col;
    logic [ATC_ROW_W-1:0]     r_row, n_row;

    logic                     r_valid, n_valid;
    logic [ATC_XY_W-1:0]      r_x, n_x, r_y, n_y;
    logic                     r_last, n_last, r_full, n_full;

    logic                     div_start, div_done;
    logic [ATC_DIVD_W-1:0]    div_quot;
    logic [ATC_GRANT_W-1:0]   quot_grant;
    logic [ATC_SQ_W-1:0]      sq_root, root_sq, grant_sq;

    // tile step signals
    logic                     need_seek;
    logic [ATC_COL_W:0]       seek1, seek2;
    logic [ATC_COL_W-1:0]     pc, start2;
    logic [ATC_ROW_W-1:0]     pr, pr_inc;
    logic [ATC_ROW_W:0]       span;
    logic                     is_last, leave;

    // first column from s (wrapping) that still has a free row; {hit, column}
    function automatic logic [ATC_COL_W:0] seek_col(input t_fill f,
                                                     input logic [ATC_COL_W-1:0] s);
        logic [ATC_COL_W-1:0] c;
        logic [ATC_COL_W-1:0] res;
        logic                 hit;
        c   = s;
        res = s;
        hit = 1'b0;
        for (int n = 0; n < ATC_SIDE; n++) begin
            if (!hit && (f[c] < SIDE_R)) begin
                res = c;
                hit = 1'b1;
            end
            c = (c == ATC_COL_W'(ATC_SIDE - 1)) ? '0 : c + 1'b1;
        end
        return {hit, res};
    endfunction

    // the divider loads at the accepting edge, so it takes the request's node count directly
    atc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ATC_DIVD_W'(i_kernel_nodes) * ATC_DIVD_W'(ATC_CELLS)),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    always_comb begin
        if (div_quot == '0) begin
            quot_grant = ATC_GRANT_W'(1);
        end else if (div_quot > ATC_DIVD_W'(ATC_CELLS)) begin
            quot_grant = ATC_GRANT_W'(ATC_CELLS);
        end else begin
            quot_grant = div_quot[ATC_GRANT_W-1:0];
        end
    end

    // r_sq holds (r+1)^2
    assign sq_root  = ATC_SQ_W'(r_root);
    assign root_sq  = r_sq - (sq_root << 1) - ATC_SQ_W'(1);
    assign grant_sq = ATC_SQ_W'(r_grant);

    always_comb begin
        need_seek = (r_fill[r_col] >= SIDE_R) || (r_row >= SIDE_R);
        seek1     = seek_col(r_fill, r_col);
        pc        = need_seek ? seek1[ATC_COL_W-1:0] : r_col;
        pr        = need_seek ? r_fill[seek1[ATC_COL_W-1:0]] : r_row;
        pr_inc    = pr + 1'b1;
        is_last   = (r_left == ATC_GRANT_W'(1));
        span      = {1'b0, pr} - {1'b0, r_fill[pc]};
        leave     = (span == {1'b0, r_height - 1'b1}) || is_last || (pr_inc >= SIDE_R);
        n_fill    = r_fill;
        n_fill[pc] = pr_inc;
        start2    = (pc == ATC_COL_W'(ATC_SIDE - 1)) ? '0 : pc + 1'b1;
        seek2     = seek_col(n_fill, start2);
    end

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_left    = r_left;
        n_valid   = 1'b0;
        n_x       = '0;
        n_y       = '0;
        n_last    = 1'b0;
        n_full    = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_total == '0) begin
                        n_state = S_ROOT;
                    end else begin
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_sq > grant_sq) begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                n_left  = r_grant;
                n_state = S_TILE;
                if ((SIDE_R - ATC_ROW_W'(r_col)) < r_width) begin
                    n_col = '0;
                    n_row = r_fill[0];
                end
            end
            S_TILE: begin
                n_valid = 1'b1;
                if (need_seek && !seek1[ATC_COL_W]) begin
                    // nothing free anywhere: flag and stop this kernel
                    n_last  = 1'b1;
                    n_full  = 1'b1;
                    n_col   = r_col;
                    n_row   = r_fill[r_col];
                    n_state = S_IDLE;
                end else begin
                    n_x    = ATC_XY_W'(pc);
                    n_y    = pr[ATC_XY_W-1:0];
                    n_last = is_last;
                    n_left = r_left - 1'b1;
                    if (leave) begin
                        n_col = seek2[ATC_COL_W-1:0];
                        n_row = n_fill[seek2[ATC_COL_W-1:0]];
                    end else begin
                        n_col = pc;
                        n_row = pr_inc;
                    end
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_IDLE && start && r_total != '0) begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= ATC_TOTAL_W'(1);
            r_fill  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_total <= i_cfg_total_nodes;
            end
            if (r_state == S_TILE && !(need_seek && !seek1[ATC_COL_W]) && leave) begin
                r_fill[pc] <= pr_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_x    <= n_x;
        r_y    <= n_y;
        r_last <= n_last;
        r_full <= n_full;
        if (r_state == S_IDLE && start) begin
            r_grant <= ATC_GRANT_W'(ATC_CELLS);
        end
        if (r_state == S_DIV && div_done) begin
            r_grant <= quot_grant;
        end
        if (n_state == S_ROOT && r_state != S_ROOT) begin
            r_root <= '0;
            r_sq   <= ATC_SQ_W'(1);
        end else if (r_state == S_ROOT) begin
            if (r_sq <= grant_sq) begin
                r_root <= r_root + 1'b1;
                r_sq   <= r_sq + (sq_root << 1) + ATC_SQ_W'(3);
            end else if (root_sq == grant_sq) begin
                r_width  <= r_root;
                r_height <= r_root;
            end else if (grant_sq <= root_sq + sq_root) begin
                r_width  <= r_root;
                r_height <= r_root + 1'b1;
            end else begin
                r_width  <= r_root + 1'b1;
                r_height <= r_root + 1'b1;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_tile_x     = r_x;
    assign o_tile_y     = r_y;
    assign o_last       = r_last;
    assign o_array_full = r_full;

    a_valid_from_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_TILE))
        else $error("result strobe without a tile step");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_full_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_array_full) |-> (o_last && o_tile_x == '0 && o_tile_y == '0))
        else $error("array full result malformed");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

endmodule

`default_nettype wire

### verif/tb_array_tile_column_allocator.sv
// Self-checking testbench for array_tile_column_allocator: kernel requests go in, and each
// tile strobe is checked against a built-in allocation predictor, over several divisor settings.
// Depends on atc_pkg and the allocator RTL only.
`default_nettype none

module tb_array_tile_column_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import atc_pkg::*;

    localparam int SIDE       = ATC_SIDE;
    localparam int CELLS      = ATC_CELLS;
    localparam int STALL_MAX  = 3000;
    localparam int SETTLE     = 40;
    localparam int RAND_PHASE = 10;
    localparam int PHASE_LEN  = 41;

    typedef struct packed {
        logic [ATC_XY_W-1:0] x;
        logic [ATC_XY_W-1:0] y;
        logic                last;
        logic                full;
    } t_tile;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [ATC_TOTAL_W-1:0] i_cfg_total_nodes = '0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [ATC_NODES_W-1:0] i_kernel_nodes = '0;
    logic                   o_valid;
    logic [ATC_XY_W-1:0]    o_tile_x;
    logic [ATC_XY_W-1:0]    o_tile_y;
    logic                   o_last;
    logic                   o_array_full;

    array_tile_column_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_total_nodes (i_cfg_total_nodes),
        .start             (start),
        .busy              (busy),
        .i_kernel_nodes    (i_kernel_nodes),
        .o_valid           (o_valid),
        .o_tile_x          (o_tile_x),
        .o_tile_y          (o_tile_y),
        .o_last            (o_last),
        .o_array_full      (o_array_full)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: column fill levels, cursor and divisor
    logic [ATC_ROW_W-1:0]   fill_lvl [SIDE];
    logic [ATC_COL_W-1:0]   cur_col = '0;
    logic [ATC_ROW_W-1:0]   cur_row = '0;
    logic [ATC_TOTAL_W-1:0] total_reg = 24'd1;

    initial begin
        for (int i = 0; i < SIDE; i++) fill_lvl[i] = '0;
    end

    logic [ATC_NODES_W-1:0] pending_kernels [$];
    t_tile                  tiles_due [$];
    int                     kernels_queued = 0;
    int                     kernels_sent = 0;
    int                     tiles_checked = 0;
    int                     full_flags = 0;
    int                     cfg_writes = 0;
    int                     mismatches = 0;
    int                     stall_cycles = 0;
    bit                     steady = 1'b0;

    // Move the cursor to the first column from 'from' (wrapping) with a free row
    function automatic bit find_open_column(int from);
        int c;
        c = from % SIDE;
        for (int n = 0; n < SIDE; n++) begin
            if (fill_lvl[c] < SIDE) begin
                cur_col = ATC_COL_W'(c);
                cur_row = fill_lvl[c];
                return 1'b1;
            end
            c = (c + 1) % SIDE;
        end
        cur_col = ATC_COL_W'(from % SIDE);
        cur_row = fill_lvl[cur_col];
        return 1'b0;
    endfunction

    function automatic void place_kernel(logic [ATC_NODES_W-1:0] nodes);
        int    grant;
        int    r;
        int    wid;
        int    hgt;
        int    left;
        int    col;
        t_tile t;
        if (total_reg == 0) grant = CELLS;
        else grant = (CELLS * int'(nodes)) / int'(total_reg);
        if (grant == 0) grant = 1;
        if (grant > CELLS) grant = CELLS;
        r = 0;
        while ((r + 1) * (r + 1) <= grant) r++;
        if (r * r == grant) begin
            wid = r;
            hgt = r;
        end else if (grant <= r * r + r) begin
            wid = r;
            hgt = r + 1;
        end else begin
            wid = r + 1;
            hgt = r + 1;
        end
        // restart at column 0 when the remaining columns are too few
        if (SIDE - int'(cur_col) < wid) begin
            cur_col = '0;
            cur_row = fill_lvl[0];
        end
        left = grant;
        while (left > 0) begin
            col = int'(cur_col);
            if (fill_lvl[col] >= SIDE || cur_row >= SIDE) begin
                if (!find_open_column(col)) begin
                    t = '{x: '0, y: '0, last: 1'b1, full: 1'b1};
                    tiles_due.push_back(t);
                    return;
                end
                col = int'(cur_col);
            end
            left--;
            t = '{x: col[ATC_XY_W-1:0], y: cur_row[ATC_XY_W-1:0],
                  last: (left == 0), full: 1'b0};
            tiles_due.push_back(t);
            if (int'(cur_row) - int'(fill_lvl[col]) == hgt - 1 || left == 0 ||
                int'(cur_row) + 1 >= SIDE) begin
                fill_lvl[col] = cur_row + 1'b1;
                void'(find_open_column(col + 1));
            end else begin
                cur_row = cur_row + 1'b1;
            end
        end
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) total_reg = i_cfg_total_nodes;
            if (start && !busy) begin
                place_kernel(i_kernel_nodes);
                kernels_sent++;
            end
            // an unaccepted request is held as it is
            if (!(start && busy)) begin
                if (pending_kernels.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
                    start          <= 1'b1;
                    i_kernel_nodes <= pending_kernels.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor and stall counter
    always @(posedge i_clk) begin
        t_tile want;
        if (i_rst_n && o_valid) begin
            tiles_checked++;
            if (o_array_full) full_flags++;
            if (tiles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected tile x=%0d y=%0d last=%0d full=%0d",
                             $realtime, o_tile_x, o_tile_y, o_last, o_array_full);
            end else begin
                want = tiles_due.pop_front();
                if (o_tile_x !== want.x || o_tile_y !== want.y || o_last !== want.last ||
                    o_array_full !== want.full) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] tile mismatch exp x=%0d y=%0d last=%0d full=%0d,",
                                  " got x=%0d y=%0d last=%0d full=%0d"},
                                 $realtime, want.x, want.y, want.last, want.full,
                                 o_tile_x, o_tile_y, o_last, o_array_full);
                end
            end
        end
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_MAX) @(posedge i_clk);
        $display("[%0t] watchdog: no progress for %0d cycles", $realtime, STALL_MAX);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic queue_kernel(int nodes);
        pending_kernels.push_back(nodes[ATC_NODES_W-1:0]);
        kernels_queued++;
    endtask

    task automatic wait_quiet();
        while (kernels_sent != kernels_queued || tiles_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_total(logic [ATC_TOTAL_W-1:0] value);
        wait_quiet();
        i_cfg_valid       <= 1'b1;
        i_cfg_total_nodes <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        logic [ATC_TOTAL_W-1:0] divisor;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // divisor at reset value: zero nodes still gets one tile
        queue_kernel(0);
        // largest divisor: every kernel rounds down to one tile
        write_total(24'hFFFFFF);
        queue_kernel(65535);
        queue_kernel(1);
        // grants 1..7 and 9, then 2 and 3, to work the width/height split and column restarts
        write_total(24'd4096);
        for (int g = 1; g <= 7; g++) queue_kernel(64 * g);
        queue_kernel(64 * 9);
        queue_kernel(64 * 2);
        queue_kernel(64 * 3);

        for (int p = 0; p < RAND_PHASE; p++) begin
            case (p)
                0:       divisor = 24'd8192;
                1:       divisor = '0;
                2:       divisor = 24'd1;
                3:       divisor = 24'hFFFFFF;
                5:       divisor = ATC_TOTAL_W'($urandom_range(1, 65535));
                default: divisor = ATC_TOTAL_W'($urandom);
            endcase
            write_total(divisor);
            steady = (p == 4);
            for (int k = 0; k < PHASE_LEN; k++) begin
                if ($urandom_range(0, 99) < 60) queue_kernel($urandom_range(0, 1023));
                else queue_kernel($urandom_range(0, 65535));
            end
        end

        wait_quiet();
        if (tiles_due.size() != 0) mismatches += tiles_due.size();
        $display("Placed %0d kernels over %0d divisor writes; %0d tile results checked,",
                 kernels_sent, cfg_writes, tiles_checked);
        $display("%0d flagged full; mismatches: %0d", full_flags, mismatches);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
